@@ sv/halfblock_pixel_cell_encoder_macros.svh @@
// Assertion macros for the half-block pixel cell encoder.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef HALFBLOCK_PIXEL_CELL_ENCODER_MACROS_SVH
`define HALFBLOCK_PIXEL_CELL_ENCODER_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define HBPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define HBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/hbpc_pkg.sv @@
// Shared types and constants of the half-block pixel cell encoder.
// No dependencies; imported by hbpc_stores and the top level.
package hbpc_pkg;

  localparam int CFG_DW     = 8;
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 7;
  localparam int PIX_W      = 24;
  localparam int CELL_W     = 48;
  localparam int DIRTY_W    = 64;
  localparam int COLS_RESET = 80;
  localparam int ROWS_RESET = 24;

  localparam logic REG_COLS      = 1'b0;
  localparam logic REG_CELL_ROWS = 1'b1;

  typedef enum logic [2:0] {
    REQ_SET       = 3'd0,
    REQ_FILL      = 3'd1,
    REQ_CLEAR     = 3'd2,
    REQ_MARK      = 3'd3,
    REQ_ENC_DIRTY = 3'd4,
    REQ_ENC_ALL   = 3'd5,
    REQ_READ      = 3'd6,
    REQ_NONE      = 3'd7
  } req_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_WPIX,
    ST_MSETUP,
    ST_MRD,
    ST_MWR,
    ST_CLR,
    ST_ALLRD,
    ST_ALLWR,
    ST_EDRD,
    ST_EDCHK,
    ST_ETOP,
    ST_EBOT,
    ST_EWR,
    ST_RDCELL,
    ST_RDOUT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic pix_we;
    logic cell_we;
    logic dirty_we;
  } mem_ctrl_t;

endpackage

@@ sv/halfblock_pixel_cell_encoder.sv @@
// Top level of the half-block pixel cell encoder: command sequencer and ports.
// Depends on hbpc_pkg, hbpc_stores and the assertion macro header.
//
// After reset the block sweeps the pixel, cell and dirty memories to zero, one
// pixel address a cycle, over all MAX_COLS*2*MAX_CELL_ROWS pixel addresses
// (16384 at the defaults); in_stall stays high meanwhile. Then it runs one
// command at a time, each walking the memories through a single port per
// memory. Set pixel writes one pixel and marks its cell dirty; fill writes each
// pixel of the rectangle and then marks each cell it covers dirty; mark only
// marks cells; clear writes every pixel and then sets the dirty words; encode
// all encodes every cell and then makes the dirty-word pass; encode dirty reads
// each cell's dirty bit and encodes only the dirty ones; read cell fetches one
// cell word and its dirty bit. A dirty mark is the read-modify-write of a dirty
// word, and encoding needs two pixel reads per cell. A finished word is held in
// the output register, so the next command can be accepted while it waits.
`include "halfblock_pixel_cell_encoder_macros.svh"
module halfblock_pixel_cell_encoder import hbpc_pkg::*; #(
  parameter int MAX_COLS      = 128,
  parameter int MAX_CELL_ROWS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_req_type,
  input  logic [7:0]        in_x_start,
  input  logic [7:0]        in_y_start,
  input  logic [7:0]        in_x_end,
  input  logic [7:0]        in_y_end,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [7:0]        out_fg_red,
  output logic [7:0]        out_fg_green,
  output logic [7:0]        out_fg_blue,
  output logic [7:0]        out_bg_red,
  output logic [7:0]        out_bg_green,
  output logic [7:0]        out_bg_blue,
  output logic              out_cell_dirty
);

  localparam int PIX_DEPTH   = MAX_COLS * 2 * MAX_CELL_ROWS;
  localparam int CELL_DEPTH  = MAX_COLS * MAX_CELL_ROWS;
  localparam int DIRTY_WORDS = (CELL_DEPTH + 63) / 64;
  localparam int PAW = $clog2(PIX_DEPTH);
  localparam int CAW = $clog2(CELL_DEPTH);
  localparam int DAW = (DIRTY_WORDS > 1) ? $clog2(DIRTY_WORDS) : 1;
  localparam int CW  = $clog2(MAX_COLS + 1);
  localparam int RW  = $clog2(MAX_CELL_ROWS + 1);
  localparam int HW  = $clog2(2 * MAX_CELL_ROWS + 1);
  localparam int VW0 = (CW > 9) ? CW : 9;
  localparam int VW  = (HW > VW0) ? HW : VW0;
  localparam int NW  = $clog2(CELL_DEPTH + 1);
  localparam int TW  = $clog2(PIX_DEPTH + 1);
  localparam int MW  = VW + CW;

  state_t state_r, state_nxt;

  logic [COLS_W-1:0] cols_r;
  logic [ROWS_W-1:0] cell_rows_r;

  req_t              op_r;
  logic [VW-1:0]     xs_r, ys_r, xe_r, ye_r;
  logic [PIX_W-1:0]  rgb_r;
  logic [CW-1:0]     c_r;
  logic [RW-1:0]     rows_r;
  logic [VW-1:0]     x_r, y_r, rend_r;
  logic [PAW:0]      base_r;
  logic [TW-1:0]     total_r, lin_r;
  logic [DAW-1:0]    w_r;
  logic [NW-1:0]     rem_r;
  logic [CW-1:0]     col_r;
  logic [PAW:0]      pbase_r;
  logic [NW-1:0]     cidx_r;
  logic [PIX_W-1:0]  top_r;
  logic [PAW-1:0]    init_r;

  logic              res_status_r, res_dirty_r;
  logic [CELL_W-1:0] res_cell_r;
  logic              out_valid_r, out_status_r, out_dirty_r;
  logic [CELL_W-1:0] out_cell_r;

  mem_ctrl_t          mem_ctrl;
  logic [PAW-1:0]     pix_addr;
  logic [PIX_W-1:0]   pix_wdata, pix_rdata;
  logic [CAW-1:0]     cell_addr;
  logic [CELL_W-1:0]  cell_wdata, cell_rdata;
  logic [DAW-1:0]     dirty_addr;
  logic [DIRTY_W-1:0] dirty_wdata, dirty_rdata;

  // Combinational helpers
  logic [CW-1:0]     eff_c;
  logic [RW-1:0]     eff_r;
  logic [HW-1:0]     h;
  logic [VW-1:0]     c_v, h_v, xe_cl, ye_cl, r0, r1, mul_a;
  logic [MW-1:0]     prod;
  logic [PAW:0]      mcidx;
  logic [NW-1:0]     ncell;
  logic              accept, x_last, y_last, enc_last, cell_bit, slot_free;
  logic              oor_set, oor_rd, fill_ne;
  logic [DIRTY_W-1:0] all_mask;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;

  assign eff_c = (cols_r == '0) ? CW'(1) :
                 ((32'(cols_r) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cols_r));
  assign eff_r = (cell_rows_r == '0) ? RW'(1) :
                 ((32'(cell_rows_r) > MAX_CELL_ROWS) ? RW'(MAX_CELL_ROWS) : RW'(cell_rows_r));

  assign h     = HW'({rows_r, 1'b0});
  assign c_v   = VW'(c_r);
  assign h_v   = VW'(h);
  assign xe_cl = (xe_r > c_v) ? c_v : xe_r;
  assign ye_cl = (ye_r > h_v) ? h_v : ye_r;
  assign r0    = ys_r >> 1;
  assign r1    = ((ye_r != '0) ? (ye_r - VW'(1)) : '0) >> 1;

  assign oor_set = (xs_r >= c_v) || (ys_r >= h_v);
  assign oor_rd  = (xs_r >= c_v) || (ys_r >= VW'(rows_r));
  assign fill_ne = (ys_r < ye_cl) && (xs_r < xe_cl);

  // One shared multiplier: row bases, pixel and cell counts, read address.
  always_comb begin
    if (state_r == ST_MSETUP) begin
      mul_a = r0;
    end else if (op_r == REQ_CLEAR || op_r == REQ_ENC_DIRTY || op_r == REQ_ENC_ALL) begin
      mul_a = h_v;
    end else begin
      mul_a = ys_r;
    end
  end
  assign prod = mul_a * c_r;

  assign mcidx    = base_r + (PAW + 1)'(x_r);
  assign ncell    = NW'(total_r >> 1);
  assign x_last   = ((x_r + VW'(1)) == xe_r);
  assign y_last   = ((y_r + VW'(1)) == ye_r);
  assign enc_last = ((cidx_r + NW'(1)) == ncell);
  assign cell_bit = dirty_rdata[cidx_r[5:0]];
  assign all_mask = (rem_r >= NW'(64)) ? '1 : ((DIRTY_W'(1) << rem_r[5:0]) - DIRTY_W'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT:   if (init_r == PAW'(PIX_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_SETUP;
      ST_SETUP: begin
        unique case (op_r)
          REQ_SET:       state_nxt = oor_set ? ST_DONE : ST_WPIX;
          REQ_FILL:      state_nxt = fill_ne ? ST_WPIX : ST_MSETUP;
          REQ_MARK:      state_nxt = ST_MSETUP;
          REQ_CLEAR:     state_nxt = ST_CLR;
          REQ_ENC_DIRTY: state_nxt = ST_EDRD;
          REQ_ENC_ALL:   state_nxt = ST_ETOP;
          REQ_READ:      state_nxt = oor_rd ? ST_DONE : ST_RDCELL;
          default:       state_nxt = ST_DONE;
        endcase
      end
      ST_WPIX:   if (x_last && y_last) state_nxt = ST_MSETUP;
      ST_MSETUP: state_nxt = ((xs_r < xe_r) && (r0 <= r1)) ? ST_MRD : ST_DONE;
      ST_MRD:    state_nxt = ST_MWR;
      ST_MWR:    state_nxt = (x_last && (y_r == rend_r)) ? ST_DONE : ST_MRD;
      ST_CLR:    if ((lin_r + TW'(1)) == total_r) state_nxt = ST_ALLRD;
      ST_ALLRD:  state_nxt = ST_ALLWR;
      ST_ALLWR:  state_nxt = (rem_r <= NW'(64)) ? ST_DONE : ST_ALLRD;
      ST_EDRD:   state_nxt = ST_EDCHK;
      ST_EDCHK: begin
        if (cell_bit) begin
          state_nxt = ST_EBOT;
        end else begin
          state_nxt = enc_last ? ST_DONE : ST_EDRD;
        end
      end
      ST_ETOP:   state_nxt = ST_EBOT;
      ST_EBOT:   state_nxt = ST_EWR;
      ST_EWR: begin
        if (enc_last) begin
          state_nxt = (op_r == REQ_ENC_ALL) ? ST_ALLRD : ST_DONE;
        end else begin
          state_nxt = (op_r == REQ_ENC_DIRTY) ? ST_EDRD : ST_ETOP;
        end
      end
      ST_RDCELL: state_nxt = ST_RDOUT;
      ST_RDOUT:  state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    mem_ctrl    = '0;
    pix_addr    = '0;
    pix_wdata   = '0;
    cell_addr   = '0;
    cell_wdata  = '0;
    dirty_addr  = '0;
    dirty_wdata = '0;
    unique case (state_r)
      ST_INIT: begin
        mem_ctrl.pix_we   = 1'b1;
        pix_addr          = init_r;
        mem_ctrl.cell_we  = (32'(init_r) < CELL_DEPTH);
        cell_addr         = CAW'(init_r);
        mem_ctrl.dirty_we = (32'(init_r) < DIRTY_WORDS);
        dirty_addr        = DAW'(init_r);
      end
      ST_WPIX: begin
        mem_ctrl.pix_we = 1'b1;
        pix_addr        = PAW'(mcidx);
        pix_wdata       = rgb_r;
      end
      ST_CLR: begin
        mem_ctrl.pix_we = 1'b1;
        pix_addr        = PAW'(lin_r);
        pix_wdata       = rgb_r;
      end
      ST_MRD: begin
        dirty_addr = DAW'(mcidx >> 6);
      end
      ST_MWR: begin
        mem_ctrl.dirty_we = 1'b1;
        dirty_addr        = DAW'(mcidx >> 6);
        dirty_wdata       = dirty_rdata | (DIRTY_W'(1) << mcidx[5:0]);
      end
      ST_ALLRD: begin
        dirty_addr = w_r;
      end
      ST_ALLWR: begin
        mem_ctrl.dirty_we = 1'b1;
        dirty_addr        = w_r;
        dirty_wdata       = dirty_rdata | all_mask;
      end
      ST_EDRD: begin
        dirty_addr = DAW'(cidx_r >> 6);
      end
      ST_EDCHK, ST_ETOP: begin
        pix_addr = PAW'(pbase_r + (PAW + 1)'(col_r));
      end
      ST_EBOT: begin
        pix_addr = PAW'(pbase_r + (PAW + 1)'(c_r) + (PAW + 1)'(col_r));
      end
      ST_EWR: begin
        mem_ctrl.cell_we = 1'b1;
        cell_addr        = CAW'(cidx_r);
        cell_wdata       = {top_r, pix_rdata};
      end
      ST_RDCELL: begin
        cell_addr  = CAW'(cidx_r);
        dirty_addr = DAW'(cidx_r >> 6);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_r      <= '0;
      cols_r      <= COLS_W'(COLS_RESET);
      cell_rows_r <= ROWS_W'(ROWS_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_INIT) begin
        init_r <= init_r + PAW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLS:      cols_r      <= cfg_data[COLS_W-1:0];
          REG_CELL_ROWS: cell_rows_r <= cfg_data[ROWS_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == ST_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= req_t'(in_req_type);
          xs_r   <= VW'(in_x_start);
          ys_r   <= VW'(in_y_start);
          xe_r   <= VW'(in_x_end);
          ye_r   <= VW'(in_y_end);
          rgb_r  <= {in_red, in_green, in_blue};
          c_r    <= eff_c;
          rows_r <= eff_r;
        end
      end
      ST_SETUP: begin
        base_r  <= (PAW + 1)'(prod);
        total_r <= TW'(prod);
        rem_r   <= NW'(prod >> 1);
        cidx_r  <= (op_r == REQ_READ) ? NW'(prod + MW'(xs_r)) : '0;
        x_r     <= xs_r;
        y_r     <= ys_r;
        lin_r   <= '0;
        w_r     <= '0;
        col_r   <= '0;
        pbase_r <= '0;
        if (op_r == REQ_SET) begin
          xe_r <= xs_r + VW'(1);
          ye_r <= ys_r + VW'(1);
        end else begin
          xe_r <= xe_cl;
          ye_r <= ye_cl;
        end
        res_status_r <= ((op_r == REQ_SET) && oor_set) || ((op_r == REQ_READ) && oor_rd);
        res_cell_r   <= '0;
        res_dirty_r  <= 1'b0;
      end
      ST_WPIX, ST_MWR: begin
        if (x_last) begin
          x_r    <= xs_r;
          y_r    <= y_r + VW'(1);
          base_r <= base_r + (PAW + 1)'(c_r);
        end else begin
          x_r <= x_r + VW'(1);
        end
      end
      ST_MSETUP: begin
        base_r <= (PAW + 1)'(prod);
        x_r    <= xs_r;
        y_r    <= r0;
        rend_r <= r1;
      end
      ST_CLR: begin
        lin_r <= lin_r + TW'(1);
      end
      ST_ALLWR: begin
        w_r   <= w_r + DAW'(1);
        rem_r <= rem_r - NW'(64);
      end
      ST_EDCHK, ST_EWR: begin
        // A clean cell is skipped here; a written cell advances after its write.
        if (state_r == ST_EWR || !cell_bit) begin
          cidx_r <= cidx_r + NW'(1);
          if ((col_r + CW'(1)) == c_r) begin
            col_r   <= '0;
            pbase_r <= pbase_r + (PAW + 1)'({c_r, 1'b0});
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
      end
      ST_EBOT: begin
        top_r <= pix_rdata;
      end
      ST_RDOUT: begin
        res_cell_r  <= cell_rdata;
        res_dirty_r <= cell_bit;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_status_r <= res_status_r;
          out_cell_r   <= res_cell_r;
          out_dirty_r  <= res_dirty_r;
        end
      end
      default: begin
      end
    endcase
  end

  hbpc_stores #(
    .PIX_DEPTH   (PIX_DEPTH),
    .CELL_DEPTH  (CELL_DEPTH),
    .DIRTY_WORDS (DIRTY_WORDS),
    .PAW         (PAW),
    .CAW         (CAW),
    .DAW         (DAW)
  ) u_stores (
    .clk         (clk),
    .ctrl        (mem_ctrl),
    .pix_addr    (pix_addr),
    .pix_wdata   (pix_wdata),
    .pix_rdata   (pix_rdata),
    .cell_addr   (cell_addr),
    .cell_wdata  (cell_wdata),
    .cell_rdata  (cell_rdata),
    .dirty_addr  (dirty_addr),
    .dirty_wdata (dirty_wdata),
    .dirty_rdata (dirty_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_fg_red     = out_cell_r[47:40];
  assign out_fg_green   = out_cell_r[39:32];
  assign out_fg_blue    = out_cell_r[31:24];
  assign out_bg_red     = out_cell_r[23:16];
  assign out_bg_green   = out_cell_r[15:8];
  assign out_bg_blue    = out_cell_r[7:0];
  assign out_cell_dirty = out_dirty_r;

  `HBPC_ASSERT_IMPL(a_idle_no_write, state_r == ST_IDLE, !mem_ctrl.pix_we && !mem_ctrl.cell_we && !mem_ctrl.dirty_we, "memory written while idle")
  `HBPC_ASSERT_IMPL(a_fill_in_frame, state_r == ST_WPIX, (x_r < c_v) && (y_r < h_v), "pixel write outside the frame")
  `HBPC_ASSERT_IMPL(a_err_word_clean, out_valid_r && out_status_r, (out_cell_r == '0) && !out_dirty_r, "error word carries cell data")
  `HBPC_ASSERT_NEXT(a_done_delivers, (state_r == ST_DONE) && slot_free, out_valid_r && (state_r == ST_IDLE), "finished command not presented")

endmodule

@@ sv/hbpc_stores.sv @@
// Pixel, cell and dirty-word memories, one port each, registered read data.
// Depends on hbpc_pkg for the write-enable bundle and word widths.
module hbpc_stores import hbpc_pkg::*; #(
  parameter int PIX_DEPTH   = 16384,
  parameter int CELL_DEPTH  = 8192,
  parameter int DIRTY_WORDS = 128,
  parameter int PAW         = 14,
  parameter int CAW         = 13,
  parameter int DAW         = 7
) (
  input  logic                clk,
  input  mem_ctrl_t           ctrl,
  input  logic [PAW-1:0]      pix_addr,
  input  logic [PIX_W-1:0]    pix_wdata,
  output logic [PIX_W-1:0]    pix_rdata,
  input  logic [CAW-1:0]      cell_addr,
  input  logic [CELL_W-1:0]   cell_wdata,
  output logic [CELL_W-1:0]   cell_rdata,
  input  logic [DAW-1:0]      dirty_addr,
  input  logic [DIRTY_W-1:0]  dirty_wdata,
  output logic [DIRTY_W-1:0]  dirty_rdata
);

  logic [PIX_W-1:0]   pix_mem   [PIX_DEPTH];
  logic [CELL_W-1:0]  cell_mem  [CELL_DEPTH];
  logic [DIRTY_W-1:0] dirty_mem [DIRTY_WORDS];

  always_ff @(posedge clk) begin
    if (ctrl.pix_we) begin
      pix_mem[pix_addr] <= pix_wdata;
    end
    pix_rdata <= pix_mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.cell_we) begin
      cell_mem[cell_addr] <= cell_wdata;
    end
    cell_rdata <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (ctrl.dirty_we) begin
      dirty_mem[dirty_addr] <= dirty_wdata;
    end
    dirty_rdata <= dirty_mem[dirty_addr];
  end

endmodule

@@ dv/halfblock_pixel_cell_encoder_tb.sv @@
// Self-checking testbench for the half-block pixel cell encoder.
// Depends on hbpc_pkg and the RTL; holds its own model of the pixel, cell and dirty stores.
module halfblock_pixel_cell_encoder_tb;
  import hbpc_pkg::*;

  typedef struct packed {
    req_t       req;
    logic [7:0] xs, ys, xe, ye, red, green, blue;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] fr, fgr, fb, br, bgr, bb;
    logic       dirty;
  } cell_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_COLS;
  logic [CFG_DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_x_start = '0, in_y_start = '0, in_x_end = '0, in_y_end = '0;
  logic [7:0] in_red = '0, in_green = '0, in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_status, out_cell_dirty;
  logic [7:0] out_fg_red, out_fg_green, out_fg_blue, out_bg_red, out_bg_green, out_bg_blue;

  halfblock_pixel_cell_encoder uut (.*);

  // Model state and geometry as the block sees it.
  logic [23:0] pix_mem [16384];
  logic [47:0] cell_mem [8192];
  bit          dirty_map [8192];
  logic [7:0]  cols_reg = 8'd80;
  logic [6:0]  rows_reg = 7'd24;

  cmd_t       pending_cmds [$];
  cell_word_t expected_words [$];
  int  errors = 0;
  int  send_idle_pct = 34, recv_idle_pct = 49;
  bit  hold_request = 0;
  int  hold_left = 0;
  bit  in_took = 0;

  initial forever #6 clk = ~clk;

  function automatic int geo_cols();
    if (cols_reg == 0) return 1;
    return (cols_reg > 128) ? 128 : int'(cols_reg);
  endfunction

  function automatic int geo_rows();
    if (rows_reg == 0) return 1;
    return (rows_reg > 64) ? 64 : int'(rows_reg);
  endfunction

  function automatic void mark_one(int idx);
    if (idx >= 0 && idx < 8192) dirty_map[idx] = 1;
  endfunction

  function automatic logic [23:0] pix_at(int idx);
    return (idx < 16384) ? pix_mem[idx] : 24'd0;
  endfunction

  function automatic void encode_one(int c, int idx);
    int top;
    top = (idx / c) * 2 * c + idx % c;
    if (idx < 8192) cell_mem[idx] = {pix_at(top), pix_at(top + c)};
  endfunction

  function automatic cell_word_t apply_cmd(cmd_t cmd);
    cell_word_t w;
    int c, rows, h, xe, ye, r1, idx;
    logic [23:0] rgb;
    w = '0;
    c = geo_cols();
    rows = geo_rows();
    h = rows * 2;
    rgb = {cmd.red, cmd.green, cmd.blue};
    case (cmd.req)
      REQ_SET: begin
        if (cmd.xs >= c || cmd.ys >= h) w.status = 1'b1;
        else begin
          pix_mem[cmd.ys * c + cmd.xs] = rgb;
          mark_one((cmd.ys >> 1) * c + cmd.xs);
        end
      end
      REQ_FILL, REQ_MARK: begin
        xe = (cmd.xe > c) ? c : int'(cmd.xe);
        ye = (cmd.ye > h) ? h : int'(cmd.ye);
        if (cmd.req == REQ_FILL)
          for (int y = cmd.ys; y < ye; y++)
            for (int x = cmd.xs; x < xe; x++) pix_mem[y * c + x] = rgb;
        r1 = (ye > 0 ? ye - 1 : 0) >> 1;
        for (int r = cmd.ys >> 1; r <= r1; r++)
          for (int x = cmd.xs; x < xe; x++) mark_one(r * c + x);
      end
      REQ_CLEAR: begin
        for (int i = 0; i < c * h; i++) pix_mem[i] = rgb;
        for (int i = 0; i < c * rows; i++) mark_one(i);
      end
      REQ_ENC_DIRTY: begin
        for (int i = 0; i < c * rows; i++) if (dirty_map[i]) encode_one(c, i);
      end
      REQ_ENC_ALL: begin
        for (int i = 0; i < c * rows; i++) encode_one(c, i);
        for (int i = 0; i < c * rows; i++) mark_one(i);
      end
      REQ_READ: begin
        if (cmd.xs >= c || cmd.ys >= rows) w.status = 1'b1;
        else begin
          idx = cmd.ys * c + cmd.xs;
          {w.fr, w.fgr, w.fb, w.br, w.bgr, w.bb} = cell_mem[idx];
          w.dirty = dirty_map[idx];
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Prediction on the input side, checking on the output side.
  always @(posedge clk) begin
    cmd_t cmd;
    cell_word_t w;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      cmd = '{req_t'(in_req_type), in_x_start, in_y_start, in_x_end, in_y_end,
              in_red, in_green, in_blue};
      expected_words.push_back(apply_cmd(cmd));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) report_mismatch("unexpected word", 8'd0, 8'd0);
      else begin
        w = expected_words.pop_front();
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
        if (out_fg_red !== w.fr) report_mismatch("fg_red", out_fg_red, w.fr);
        if (out_fg_green !== w.fgr) report_mismatch("fg_green", out_fg_green, w.fgr);
        if (out_fg_blue !== w.fb) report_mismatch("fg_blue", out_fg_blue, w.fb);
        if (out_bg_red !== w.br) report_mismatch("bg_red", out_bg_red, w.br);
        if (out_bg_green !== w.bgr) report_mismatch("bg_green", out_bg_green, w.bgr);
        if (out_bg_blue !== w.bb) report_mismatch("bg_blue", out_bg_blue, w.bb);
        if (out_cell_dirty !== w.dirty) report_mismatch("cell_dirty", out_cell_dirty, w.dirty);
      end
    end
  end

  // Command driver: a new word is offered only once the last one has gone.
  always @(negedge clk) begin
    cmd_t cmd;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_cmds.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        cmd = pending_cmds.pop_front();
        in_req_type <= cmd.req;
        in_x_start <= cmd.xs;
        in_y_start <= cmd.ys;
        in_x_end <= cmd.xe;
        in_y_end <= cmd.ye;
        in_red <= cmd.red;
        in_green <= cmd.green;
        in_blue <= cmd.blue;
        in_valid <= 1'b1;
      end else in_valid <= 1'b0;
    end
  end

  // Result receiver; a requested hold keeps stall high for a long run of cycles.
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = 300;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  task automatic push_cmd(req_t req, int xs, int ys, int xe, int ye, int r, int g, int b);
    pending_cmds.push_back('{req, xs[7:0], ys[7:0], xe[7:0], ye[7:0], r[7:0], g[7:0], b[7:0]});
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || in_valid || expected_words.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_geometry(logic [7:0] c, logic [7:0] r);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COLS;
    cfg_data <= c;
    @(negedge clk);
    cfg_index <= REG_CELL_ROWS;
    cfg_data <= r;
    @(negedge clk);
    cfg_we <= 1'b0;
    cols_reg = c;
    rows_reg = r[6:0];
  endtask

  // Random commands with small rectangles; heavy whole-store commands only when allowed.
  task automatic push_random(int n, bit heavy);
    int c, h, req, xs, ys;
    for (int k = 0; k < n; k++) begin
      c = geo_cols();
      h = geo_rows() * 2;
      req = $urandom_range(7, 0);
      if (!heavy && (req == REQ_CLEAR || req == REQ_ENC_ALL)) req = REQ_ENC_DIRTY;
      if ($urandom_range(7, 0) == 0) begin
        xs = $urandom_range(255, 0);
        ys = $urandom_range(255, 0);
      end else begin
        xs = $urandom_range(c, 0);
        ys = (req == REQ_READ) ? $urandom_range(h / 2, 0) : $urandom_range(h, 0);
      end
      push_cmd(req_t'(req), xs, ys,
               ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0) : xs + $urandom_range(9, 0),
               ($urandom_range(7, 0) == 0) ? $urandom_range(255, 0) : ys + $urandom_range(9, 0),
               $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0));
    end
  endtask

  initial begin
    foreach (pix_mem[i]) pix_mem[i] = '0;
    foreach (cell_mem[i]) cell_mem[i] = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: small geometry, corners, refusals, clamping and every command.
    write_geometry(8'd4, 8'd2);
    push_cmd(REQ_SET, 0, 0, 0, 0, 255, 255, 255);
    push_cmd(REQ_SET, 3, 3, 0, 0, 0, 0, 0);
    push_cmd(REQ_SET, 4, 0, 0, 0, 1, 2, 3);
    push_cmd(REQ_SET, 0, 4, 0, 0, 1, 2, 3);
    push_cmd(REQ_SET, 255, 255, 255, 255, 255, 255, 255);
    push_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_ENC_DIRTY, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 3, 1, 0, 0, 0, 0, 0);
    push_cmd(REQ_FILL, 1, 1, 255, 255, 170, 85, 15);
    push_cmd(REQ_FILL, 3, 2, 2, 1, 9, 9, 9);
    push_cmd(REQ_MARK, 0, 0, 4, 0, 0, 0, 0);
    push_cmd(REQ_MARK, 2, 1, 3, 4, 0, 0, 0);
    push_cmd(REQ_ENC_DIRTY, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 2, 1, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 4, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 0, 2, 0, 0, 0, 0, 0);
    push_cmd(REQ_NONE, 255, 255, 255, 255, 255, 255, 255);
    push_cmd(REQ_CLEAR, 0, 0, 0, 0, 255, 0, 255);
    push_cmd(REQ_ENC_ALL, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 1, 1, 0, 0, 0, 0, 0);
    push_cmd(REQ_CLEAR, 0, 0, 0, 0, 0, 255, 0);
    push_cmd(REQ_READ, 1, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // Geometry change rereads the stores through the new mapping.
    send_idle_pct = 34;
    recv_idle_pct = 49;
    write_geometry(8'd6, 8'd3);
    push_random(25, 1);
    wait_drained();

    // Registers of zero act as one; the long hold fills the block up.
    send_idle_pct = 49;
    recv_idle_pct = 34;
    write_geometry(8'd0, 8'd0);
    hold_request = 1;
    push_random(25, 1);
    wait_drained();

    // Largest geometry, and values above the limits that clamp to it.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_geometry(8'd128, 8'd64);
    push_cmd(REQ_FILL, 120, 120, 255, 255, 18, 52, 86);
    push_cmd(REQ_SET, 127, 127, 0, 0, 7, 8, 9);
    push_cmd(REQ_ENC_DIRTY, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 127, 63, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 128, 64, 0, 0, 0, 0, 0);
    push_random(6, 0);
    wait_drained();
    write_geometry(8'd255, 8'd127);
    push_cmd(REQ_ENC_ALL, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(REQ_READ, 121, 60, 0, 0, 0, 0, 0);
    push_random(6, 0);
    wait_drained();

    write_geometry(8'd13, 8'd5);
    push_random(20, 1);
    wait_drained();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #(12 * 3000000);
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/hbpc_pkg.sv
sv/hbpc_stores.sv
sv/halfblock_pixel_cell_encoder.sv
dv/halfblock_pixel_cell_encoder_tb.sv
